// ----- hdl/chbd_pkg.sv -----
package chbd_pkg;

  // Size field and body length widths
  localparam int SIZE_BITS   = 32;
  localparam int LENGTH_BITS = 24;

  // Depth of the queue between parser and emitter
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Result kinds
  localparam logic [1:0] KIND_PAYLOAD  = 2'd0;
  localparam logic [1:0] KIND_COMPLETE = 2'd1;
  localparam logic [1:0] KIND_ERROR    = 2'd2;

  // Error codes
  localparam logic [1:0] ERR_SIZE_LINE  = 2'd0;
  localparam logic [1:0] ERR_TERMINATOR = 2'd1;
  localparam logic [1:0] ERR_EARLY_END  = 2'd2;

  // Characters of the line syntax
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;

  // One queued input transaction: its first result, and whether an
  // early-end error follows it
  typedef struct packed {
    logic [1:0]             kind;
    logic [7:0]             payload_byte;
    logic [1:0]             error_code;
    logic [LENGTH_BITS-1:0] body_length;
    logic                   extra_eod;
  } chbd_entry_t;

endpackage

// ----- hdl/chbd_front.sv -----
module chbd_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  logic [7:0]           in_data_byte,
  input  logic                 in_end_of_data,
  output logic                 push,
  output chbd_pkg::chbd_entry_t push_entry
);
  import chbd_pkg::*;

  localparam logic [3:0] PH_LEAD       = 4'd0;
  localparam logic [3:0] PH_DIGITS     = 4'd1;
  localparam logic [3:0] PH_EXT        = 4'd2;
  localparam logic [3:0] PH_SIZE_LF    = 4'd3;
  localparam logic [3:0] PH_DATA       = 4'd4;
  localparam logic [3:0] PH_DATA_CR    = 4'd5;
  localparam logic [3:0] PH_DATA_LF    = 4'd6;
  localparam logic [3:0] PH_TR_START   = 4'd7;
  localparam logic [3:0] PH_TR_LINE    = 4'd8;
  localparam logic [3:0] PH_TR_LINE_LF = 4'd9;
  localparam logic [3:0] PH_TR_END_LF  = 4'd10;

  logic [3:0]             phase_r, phase_nxt;
  logic [SIZE_BITS-1:0]   chunk_r, chunk_nxt;
  logic [LENGTH_BITS-1:0] len_r, len_nxt;
  logic                   discard_r, discard_nxt;

  logic                   accept;
  logic                   hex_ok;
  logic [3:0]             hex_v;
  logic                   first_vld;
  logic [1:0]             first_kind;
  logic [7:0]             first_byte;
  logic [1:0]             first_err;
  logic [LENGTH_BITS-1:0] first_len;
  logic                   eod_err;

  assign accept = in_valid && !in_stall;

  // Decode a hex digit
  always_comb begin
    hex_ok = 1'b1;
    hex_v  = 4'd0;
    if (in_data_byte >= "0" && in_data_byte <= "9") begin
      hex_v = 4'(in_data_byte - "0");
    end else if (in_data_byte >= "a" && in_data_byte <= "f") begin
      hex_v = 4'(in_data_byte - "a" + 8'd10);
    end else if (in_data_byte >= "A" && in_data_byte <= "F") begin
      hex_v = 4'(in_data_byte - "A" + 8'd10);
    end else begin
      hex_ok = 1'b0;
    end
  end

  // Classify the byte and advance the parse state
  always_comb begin
    phase_nxt   = phase_r;
    chunk_nxt   = chunk_r;
    len_nxt     = len_r;
    discard_nxt = discard_r;
    first_vld   = 1'b0;
    first_kind  = KIND_ERROR;
    first_byte  = 8'd0;
    first_err   = ERR_SIZE_LINE;
    first_len   = '0;
    eod_err     = 1'b0;

    if (!discard_r) begin
      case (phase_r)
        PH_LEAD: begin
          if (in_data_byte == CH_SPACE || in_data_byte == CH_TAB) begin
            phase_nxt = PH_LEAD;
          end else if (hex_ok) begin
            chunk_nxt = {{(SIZE_BITS-4){1'b0}}, hex_v};
            phase_nxt = PH_DIGITS;
          end else begin
            first_vld   = 1'b1;
            discard_nxt = 1'b1;
          end
        end
        PH_DIGITS: begin
          if (hex_ok) begin
            if (chunk_r[SIZE_BITS-1 -: 4] != 4'd0) begin
              first_vld   = 1'b1;
              discard_nxt = 1'b1;
            end else begin
              chunk_nxt = {chunk_r[SIZE_BITS-5:0], hex_v};
            end
          end else if (in_data_byte == CH_CR) begin
            phase_nxt = PH_SIZE_LF;
          end else begin
            phase_nxt = PH_EXT;
          end
        end
        PH_EXT: begin
          if (in_data_byte == CH_CR) phase_nxt = PH_SIZE_LF;
        end
        PH_SIZE_LF: begin
          if (in_data_byte != CH_LF) begin
            first_vld   = 1'b1;
            discard_nxt = 1'b1;
          end else begin
            phase_nxt = (chunk_r == '0) ? PH_TR_START : PH_DATA;
          end
        end
        PH_DATA: begin
          first_vld  = 1'b1;
          first_kind = KIND_PAYLOAD;
          first_byte = in_data_byte;
          if (len_r != '1) len_nxt = len_r + 1'b1;
          chunk_nxt = chunk_r - 1'b1;
          if (chunk_r == {{(SIZE_BITS-1){1'b0}}, 1'b1}) phase_nxt = PH_DATA_CR;
        end
        PH_DATA_CR: begin
          if (in_data_byte != CH_CR) begin
            first_vld   = 1'b1;
            first_err   = ERR_TERMINATOR;
            discard_nxt = 1'b1;
          end else begin
            phase_nxt = PH_DATA_LF;
          end
        end
        PH_DATA_LF: begin
          if (in_data_byte != CH_LF) begin
            first_vld   = 1'b1;
            first_err   = ERR_TERMINATOR;
            discard_nxt = 1'b1;
          end else begin
            phase_nxt = PH_LEAD;
          end
        end
        PH_TR_START: begin
          phase_nxt = (in_data_byte == CH_CR) ? PH_TR_END_LF : PH_TR_LINE;
        end
        PH_TR_LINE: begin
          if (in_data_byte == CH_CR) phase_nxt = PH_TR_LINE_LF;
        end
        PH_TR_LINE_LF: begin
          if (in_data_byte == CH_LF) phase_nxt = PH_TR_START;
          else if (in_data_byte != CH_CR) phase_nxt = PH_TR_LINE;
        end
        default: begin
          // Empty line ends the trailer
          if (in_data_byte == CH_LF) begin
            first_vld   = 1'b1;
            first_kind  = KIND_COMPLETE;
            first_len   = len_r;
            discard_nxt = 1'b1;
          end else begin
            phase_nxt = (in_data_byte == CH_CR) ? PH_TR_LINE_LF : PH_TR_LINE;
          end
        end
      endcase
    end

    // End of message: flag an early end, then start over
    if (in_end_of_data) begin
      eod_err     = !discard_nxt;
      phase_nxt   = PH_LEAD;
      chunk_nxt   = '0;
      len_nxt     = '0;
      discard_nxt = 1'b0;
    end
  end

  // Build the queue entry
  always_comb begin
    push = accept && (first_vld || eod_err);
    if (first_vld) begin
      push_entry.kind         = first_kind;
      push_entry.payload_byte = first_byte;
      push_entry.error_code   = first_err;
      push_entry.body_length  = first_len;
      push_entry.extra_eod    = eod_err;
    end else begin
      push_entry.kind         = KIND_ERROR;
      push_entry.payload_byte = 8'd0;
      push_entry.error_code   = ERR_EARLY_END;
      push_entry.body_length  = '0;
      push_entry.extra_eod    = 1'b0;
    end
  end

  // Update state on each accepted transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_LEAD;
      chunk_r   <= '0;
      len_r     <= '0;
      discard_r <= 1'b0;
    end else if (accept) begin
      phase_r   <= phase_nxt;
      chunk_r   <= chunk_nxt;
      len_r     <= len_nxt;
      discard_r <= discard_nxt;
    end
  end

endmodule

// ----- hdl/chbd_queue.sv -----
module chbd_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  chbd_pkg::chbd_entry_t push_entry,
  input  logic                  pop,
  output chbd_pkg::chbd_entry_t head_entry,
  output logic                  empty,
  output logic                  full
);
  import chbd_pkg::*;

  chbd_entry_t       mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] count_r, count_nxt;

  assign empty      = (count_r == '0);
  assign full       = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign head_entry = mem_r[rd_ptr_r];

  // Track occupancy
  always_comb begin
    count_nxt = count_r;
    if (push && !pop) count_nxt = count_r + 1'b1;
    else if (pop && !push) count_nxt = count_r - 1'b1;
  end

  // Write entries
  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_entry;
  end

  // Advance pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      count_r <= count_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push) else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    empty |-> !pop) else $error("queue pop while empty");
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= QCNT_W'(QUEUE_DEPTH)) else $error("queue count out of range");

endmodule

// ----- hdl/chbd_back.sv -----
module chbd_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  chbd_pkg::chbd_entry_t        head_entry,
  input  logic                         empty,
  output logic                         pop,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [1:0]                   out_kind,
  output logic [7:0]                   out_payload_byte,
  output logic [1:0]                   out_error_code,
  output logic [chbd_pkg::LENGTH_BITS-1:0] out_body_length,
  output logic                         out_run_last
);
  import chbd_pkg::*;

  logic                   valid_r;
  logic                   pending_r;
  logic                   load;
  logic [1:0]             kind_r;
  logic [7:0]             byte_r;
  logic [1:0]             err_r;
  logic [LENGTH_BITS-1:0] len_r;
  logic                   last_r;

  assign load = !valid_r || !out_stall;
  assign pop  = load && !pending_r && !empty;

  // Control: output valid and the pending early-end error
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r   <= 1'b0;
      pending_r <= 1'b0;
    end else if (load) begin
      if (pending_r) begin
        valid_r   <= 1'b1;
        pending_r <= 1'b0;
      end else if (!empty) begin
        valid_r   <= 1'b1;
        pending_r <= head_entry.extra_eod;
      end else begin
        valid_r <= 1'b0;
      end
    end
  end

  // Payload of the output register
  always_ff @(posedge clk) begin
    if (load) begin
      if (pending_r) begin
        kind_r <= KIND_ERROR;
        byte_r <= 8'd0;
        err_r  <= ERR_EARLY_END;
        len_r  <= '0;
        last_r <= 1'b1;
      end else begin
        kind_r <= head_entry.kind;
        byte_r <= head_entry.payload_byte;
        err_r  <= head_entry.error_code;
        len_r  <= head_entry.body_length;
        last_r <= !head_entry.extra_eod;
      end
    end
  end

  assign out_valid        = valid_r;
  assign out_kind         = kind_r;
  assign out_payload_byte = byte_r;
  assign out_error_code   = err_r;
  assign out_body_length  = len_r;
  assign out_run_last     = last_r;

  a_pending_shown: assert property (@(posedge clk) disable iff (!rst_n)
    pending_r |-> valid_r && !last_r) else $error("pending error without a first result");
  a_pending_next: assert property (@(posedge clk) disable iff (!rst_n)
    pending_r && !out_stall |=> valid_r && last_r && kind_r == KIND_ERROR)
    else $error("early-end error not emitted");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && out_stall |=> valid_r && $stable(last_r) && $stable(kind_r))
    else $error("stalled result changed");

endmodule

// ----- hdl/http_chunked_body_decoder_unit.sv -----
// The first result of an accepted byte is written into the queue and then
// loaded into the output register when the output does not stall.
// Throughput: one byte per cycle while in_stall is low; a payload byte that
// also ends the message gives two results, presented one after the other.
// A 4-entry queue sits between the byte parser and the result register.
// Reset: rst_n synchronous active low; clears parse state, queue and output.
module http_chunked_body_decoder_unit (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [7:0]                       in_data_byte,
  input  logic                             in_end_of_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [1:0]                       out_kind,
  output logic [7:0]                       out_payload_byte,
  output logic [1:0]                       out_error_code,
  output logic [chbd_pkg::LENGTH_BITS-1:0] out_body_length,
  output logic                             out_run_last
);
  import chbd_pkg::*;

  logic        push;
  logic        pop;
  logic        empty;
  logic        full;
  chbd_entry_t push_entry;
  chbd_entry_t head_entry;

  // Stall input while the queue has no room
  assign in_stall = full;

  chbd_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (full),
    .in_data_byte   (in_data_byte),
    .in_end_of_data (in_end_of_data),
    .push           (push),
    .push_entry     (push_entry)
  );

  chbd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head_entry (head_entry),
    .empty      (empty),
    .full       (full)
  );

  chbd_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .head_entry       (head_entry),
    .empty            (empty),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_kind         (out_kind),
    .out_payload_byte (out_payload_byte),
    .out_error_code   (out_error_code),
    .out_body_length  (out_body_length),
    .out_run_last     (out_run_last)
  );

endmodule

// ----- tb/http_chunked_body_decoder_unit_tb.sv -----
module http_chunked_body_decoder_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import chbd_pkg::*;

  // Characters used to build size lines
  localparam logic [7:0] CH_DIGIT0  = 8'h30;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_SEMI    = 8'h3B;

  localparam int N_RANDOM_ITEMS = 1600;

  typedef enum logic [3:0] {
    P_LEAD, P_DIGITS, P_EXT, P_SIZE_LF, P_DATA, P_DATA_CR, P_DATA_LF,
    P_TR_START, P_TR_LINE, P_TR_LINE_LF, P_TR_END_LF
  } parse_phase_e;

  typedef struct packed {
    logic [1:0]             kind;
    logic [7:0]             pbyte;
    logic [1:0]             ecode;
    logic [LENGTH_BITS-1:0] blen;
    logic                   last;
  } result_t;

  // One input transaction; rows marked fixed carry their single result
  typedef struct packed {
    logic [7:0]             data;
    logic                   eod;
    logic                   fixed;
    logic [1:0]             f_kind;
    logic [1:0]             f_err;
    logic [LENGTH_BITS-1:0] f_len;
  } byte_item_t;

  localparam int N_DIRECTED = 25;
  localparam byte_item_t DIRECTED_TBL [N_DIRECTED] = '{
    // blanks, digit, extension, one data byte, terminator
    '{CH_SPACE,   1'b0, 1'b0, KIND_PAYLOAD,  ERR_SIZE_LINE,  '0},
    '{CH_TAB,     1'b0, 1'b0, KIND_PAYLOAD,  ERR_SIZE_LINE,  '0},
    '{8'h31,      1'b0, 1'b0, KIND_PAYLOAD,  ERR_SIZE_LINE,  '0},
    '{CH_SEMI,    1'b0, 1'b0, KIND_PAYLOAD,  ERR_SIZE_LINE,  '0},
    '{CH_CR,      1'b0, 1'b0, KIND_PAYLOAD,  ERR_SIZE_LINE,  '0},
    '{CH_LF,      1'b0, 1'b0, KIND_PAYLOAD,  ERR_SIZE_LINE,  '0},
    '{8'h00,      1'b0, 1'b0, KIND_PAYLOAD,  ERR_SIZE_LINE,  '0},
    '{CH_CR,      1'b0, 1'b0, KIND_PAYLOAD,  ERR_SIZE_LINE,  '0},
    '{CH_LF,      1'b0, 1'b0, KIND_PAYLOAD,  ERR_SIZE_LINE,  '0},
    // zero chunk, one trailer line with a bare CR, empty line
    '{CH_DIGIT0,  1'b0, 1'b0, KIND_PAYLOAD,  ERR_SIZE_LINE,  '0},
    '{CH_CR,      1'b0, 1'b0, KIND_PAYLOAD,  ERR_SIZE_LINE,  '0},
    '{CH_LF,      1'b0, 1'b0, KIND_PAYLOAD,  ERR_SIZE_LINE,  '0},
    '{8'h54,      1'b0, 1'b0, KIND_PAYLOAD,  ERR_SIZE_LINE,  '0},
    '{CH_CR,      1'b0, 1'b0, KIND_PAYLOAD,  ERR_SIZE_LINE,  '0},
    '{CH_CR,      1'b0, 1'b0, KIND_PAYLOAD,  ERR_SIZE_LINE,  '0},
    '{CH_LF,      1'b0, 1'b0, KIND_PAYLOAD,  ERR_SIZE_LINE,  '0},
    '{CH_CR,      1'b0, 1'b0, KIND_PAYLOAD,  ERR_SIZE_LINE,  '0},
    '{CH_LF,      1'b0, 1'b1, KIND_COMPLETE, ERR_SIZE_LINE,  LENGTH_BITS'(1)},
    // ignored after completion, end of message
    '{8'hFF,      1'b1, 1'b0, KIND_PAYLOAD,  ERR_SIZE_LINE,  '0},
    // size line with no digits
    '{8'h47,      1'b0, 1'b1, KIND_ERROR,    ERR_SIZE_LINE,  '0},
    '{8'h00,      1'b1, 1'b0, KIND_PAYLOAD,  ERR_SIZE_LINE,  '0},
    // message ends inside a chunk: payload, then early-end error
    '{8'h66,      1'b0, 1'b0, KIND_PAYLOAD,  ERR_SIZE_LINE,  '0},
    '{CH_CR,      1'b0, 1'b0, KIND_PAYLOAD,  ERR_SIZE_LINE,  '0},
    '{CH_LF,      1'b0, 1'b0, KIND_PAYLOAD,  ERR_SIZE_LINE,  '0},
    '{8'hA5,      1'b1, 1'b0, KIND_PAYLOAD,  ERR_SIZE_LINE,  '0}
  };

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   in_valid;
  logic                   in_stall;
  logic [7:0]             in_data_byte;
  logic                   in_end_of_data;
  logic                   out_valid;
  logic                   out_stall;
  logic [1:0]             out_kind;
  logic [7:0]             out_payload_byte;
  logic [1:0]             out_error_code;
  logic [LENGTH_BITS-1:0] out_body_length;
  logic                   out_run_last;

  http_chunked_body_decoder_unit uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_data_byte     (in_data_byte),
    .in_end_of_data   (in_end_of_data),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_kind         (out_kind),
    .out_payload_byte (out_payload_byte),
    .out_error_code   (out_error_code),
    .out_body_length  (out_body_length),
    .out_run_last     (out_run_last)
  );

  always #1 clk = ~clk;

  // Decoder state mirrored by the predictor
  parse_phase_e           dec_phase = P_LEAD;
  logic [SIZE_BITS-1:0]   dec_chunk_left = '0;
  logic [LENGTH_BITS-1:0] dec_body_len = '0;
  logic                   dec_discard = 1'b0;

  byte_item_t stim_q[$];
  result_t    step_results[$];
  result_t    pending_results[$];

  int accepted_bytes = 0;
  int msg_count = 0;
  int n_payload = 0;
  int n_complete = 0;
  int n_error = 0;
  int err_cnt = 0;

  function automatic int hex_nibble(input logic [7:0] b);
    if (b >= CH_DIGIT0 && b <= CH_DIGIT0 + 9) return int'(b - CH_DIGIT0);
    if (b >= CH_LOWER_A && b <= CH_LOWER_A + 5) return int'(b - CH_LOWER_A) + 10;
    if (b >= CH_UPPER_A && b <= CH_UPPER_A + 5) return int'(b - CH_UPPER_A) + 10;
    return -1;
  endfunction

  task automatic add_result(input logic [1:0] kind, input logic [7:0] pbyte,
                            input logic [1:0] ecode, input logic [LENGTH_BITS-1:0] blen);
    step_results.insert(step_results.size(), result_t'{kind, pbyte, ecode, blen, 1'b0});
  endtask

  // Advance the decoder by one byte and collect the results it causes
  task automatic chunk_decode_step(input logic [7:0] b, input logic eod);
    int v;
    v = hex_nibble(b);
    step_results.delete();
    if (!dec_discard) begin
      case (dec_phase)
        P_LEAD: begin
          if (b != CH_SPACE && b != CH_TAB) begin
            if (v >= 0) begin
              dec_chunk_left = SIZE_BITS'(v);
              dec_phase = P_DIGITS;
            end else begin
              add_result(KIND_ERROR, 8'h00, ERR_SIZE_LINE, '0);
              dec_discard = 1'b1;
            end
          end
        end
        P_DIGITS: begin
          if (v >= 0) begin
            if (dec_chunk_left[SIZE_BITS-1 -: 4] != 4'h0) begin
              add_result(KIND_ERROR, 8'h00, ERR_SIZE_LINE, '0);
              dec_discard = 1'b1;
            end else begin
              dec_chunk_left = {dec_chunk_left[SIZE_BITS-5:0], 4'(v)};
            end
          end else if (b == CH_CR) begin
            dec_phase = P_SIZE_LF;
          end else begin
            dec_phase = P_EXT;
          end
        end
        P_EXT: begin
          if (b == CH_CR) dec_phase = P_SIZE_LF;
        end
        P_SIZE_LF: begin
          if (b != CH_LF) begin
            add_result(KIND_ERROR, 8'h00, ERR_SIZE_LINE, '0);
            dec_discard = 1'b1;
          end else begin
            dec_phase = (dec_chunk_left == '0) ? P_TR_START : P_DATA;
          end
        end
        P_DATA: begin
          add_result(KIND_PAYLOAD, b, ERR_SIZE_LINE, '0);
          if (dec_body_len != '1) dec_body_len = dec_body_len + 1'b1;
          dec_chunk_left = dec_chunk_left - 1'b1;
          if (dec_chunk_left == '0) dec_phase = P_DATA_CR;
        end
        P_DATA_CR: begin
          if (b != CH_CR) begin
            add_result(KIND_ERROR, 8'h00, ERR_TERMINATOR, '0);
            dec_discard = 1'b1;
          end else begin
            dec_phase = P_DATA_LF;
          end
        end
        P_DATA_LF: begin
          if (b != CH_LF) begin
            add_result(KIND_ERROR, 8'h00, ERR_TERMINATOR, '0);
            dec_discard = 1'b1;
          end else begin
            dec_phase = P_LEAD;
          end
        end
        P_TR_START: dec_phase = (b == CH_CR) ? P_TR_END_LF : P_TR_LINE;
        P_TR_LINE: begin
          if (b == CH_CR) dec_phase = P_TR_LINE_LF;
        end
        P_TR_LINE_LF: begin
          if (b == CH_LF) dec_phase = P_TR_START;
          else if (b != CH_CR) dec_phase = P_TR_LINE;
        end
        default: begin
          if (b == CH_LF) begin
            add_result(KIND_COMPLETE, 8'h00, ERR_SIZE_LINE, dec_body_len);
            dec_discard = 1'b1;
          end else begin
            dec_phase = (b == CH_CR) ? P_TR_LINE_LF : P_TR_LINE;
          end
        end
      endcase
    end
    // End of message: report an unfinished body, then start over
    if (eod) begin
      if (!dec_discard) add_result(KIND_ERROR, 8'h00, ERR_EARLY_END, '0);
      dec_phase = P_LEAD;
      dec_chunk_left = '0;
      dec_body_len = '0;
      dec_discard = 1'b0;
    end
    if (step_results.size() > 0) step_results[step_results.size()-1].last = 1'b1;
  endtask

  // Stimulus builders
  task automatic push_byte(input logic [7:0] b);
    stim_q.insert(stim_q.size(),
                  byte_item_t'{b, 1'b0, 1'b0, KIND_PAYLOAD, ERR_SIZE_LINE, '0});
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    if (nib < 10) return CH_DIGIT0 + 8'(nib);
    return (($urandom_range(0, 1) == 1) ? CH_UPPER_A : CH_LOWER_A) + 8'(nib - 10);
  endfunction

  function automatic logic [7:0] rand_byte_except(input logic [7:0] avoid);
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    return (b == avoid) ? CH_SEMI : b;
  endfunction

  task automatic push_size_line(input int unsigned n);
    int nd;
    int k;
    repeat ($urandom_range(0, 2)) push_byte(($urandom_range(0, 1) == 1) ? CH_SPACE : CH_TAB);
    repeat ($urandom_range(0, 2)) push_byte(CH_DIGIT0);
    nd = 1;
    while (nd < 8 && (n >> (4 * nd)) != 0) nd++;
    for (k = nd - 1; k >= 0; k--) push_byte(hex_char(4'(n >> (4 * k))));
    // optional extension, ignored up to CR
    if ($urandom_range(0, 3) == 0) begin
      push_byte(($urandom_range(0, 1) == 1) ? CH_SEMI : CH_SPACE);
      repeat ($urandom_range(0, 5)) push_byte(rand_byte_except(CH_CR));
    end
    push_byte(CH_CR);
    push_byte(CH_LF);
  endtask

  // Close a message: end of data on the last byte, or after some junk
  task automatic close_message();
    if ($urandom_range(0, 2) != 0)
      repeat ($urandom_range(1, 3)) push_byte(8'($urandom_range(0, 255)));
    stim_q[stim_q.size()-1].eod = 1'b1;
  endtask

  task automatic gen_wellformed(input bit mutate);
    int start;
    int sz;
    int p;
    start = stim_q.size();
    repeat ($urandom_range(0, 4)) begin
      sz = ($urandom_range(0, 15) == 0) ? $urandom_range(17, 60) : $urandom_range(1, 8);
      push_size_line(sz);
      repeat (sz) push_byte(8'($urandom_range(0, 255)));
      push_byte(CH_CR);
      push_byte(CH_LF);
    end
    push_size_line(0);
    repeat ($urandom_range(0, 2)) begin
      repeat ($urandom_range(1, 6)) push_byte(8'($urandom_range(0, 255)));
      push_byte(CH_CR);
      push_byte(CH_LF);
    end
    push_byte(CH_CR);
    push_byte(CH_LF);
    if (mutate) begin
      p = $urandom_range(start, stim_q.size() - 1);
      case ($urandom_range(0, 2))
        0: begin
          // cut the message short
          while (stim_q.size() > p + 1) void'(stim_q.pop_back());
          stim_q[p].eod = 1'b1;
          return;
        end
        1: stim_q[p].data = 8'($urandom_range(0, 255));
        default: stim_q[p].data = CH_CR;
      endcase
    end
    close_message();
  endtask

  task automatic gen_message();
    int sel;
    sel = $urandom_range(0, 19);
    msg_count++;
    if (sel < 14) begin
      gen_wellformed($urandom_range(0, 9) < 3);
    end else if (sel < 16) begin
      // size too wide for the size field
      repeat ($urandom_range(0, 1)) push_byte(CH_SPACE);
      push_byte(hex_char(4'($urandom_range(1, 15))));
      repeat ($urandom_range(8, 10)) push_byte(hex_char(4'($urandom_range(0, 15))));
      push_byte(CH_CR);
      push_byte(CH_LF);
      close_message();
    end else if (sel < 17) begin
      // CR on the size line without LF
      push_byte(hex_char(4'($urandom_range(0, 15))));
      push_byte(CH_CR);
      push_byte(rand_byte_except(CH_LF));
      close_message();
    end else if (sel < 19) begin
      repeat ($urandom_range(1, 12)) push_byte(8'($urandom_range(0, 255)));
      stim_q[stim_q.size()-1].eod = 1'b1;
    end else begin
      gen_wellformed(1'b0);
    end
  endtask

  // Check results against the oldest expectation, then predict new bytes
  always @(posedge clk) begin
    result_t got;
    result_t want;
    byte_item_t row;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        got = '{out_kind, out_payload_byte, out_error_code, out_body_length, out_run_last};
        if (pending_results.size() == 0) begin
          err_cnt++;
          $display("%t: unexpected result kind=%0d byte=%02h err=%0d len=%0d last=%0d",
                   $realtime, got.kind, got.pbyte, got.ecode, got.blen, got.last);
        end else begin
          want = pending_results.pop_front();
          if (got !== want) begin
            err_cnt++;
            $display("%t: mismatch expected kind=%0d byte=%02h err=%0d len=%0d last=%0d",
                     $realtime, want.kind, want.pbyte, want.ecode, want.blen, want.last);
            $display("%t:          actual   kind=%0d byte=%02h err=%0d len=%0d last=%0d",
                     $realtime, got.kind, got.pbyte, got.ecode, got.blen, got.last);
          end
          case (want.kind)
            KIND_PAYLOAD:  n_payload++;
            KIND_COMPLETE: n_complete++;
            default:       n_error++;
          endcase
        end
      end
      if (in_valid && !in_stall) begin
        row = stim_q[accepted_bytes];
        accepted_bytes++;
        chunk_decode_step(in_data_byte, in_end_of_data);
        if (row.fixed)
          pending_results.insert(pending_results.size(),
                                 result_t'{row.f_kind, 8'h00, row.f_err, row.f_len, 1'b1});
        else
          foreach (step_results[j])
            pending_results.insert(pending_results.size(), step_results[j]);
      end
    end
  end

  // Receiver: stall in modes of random length
  initial begin
    int mode;
    int cnt;
    out_stall = 1'b0;
    cnt = 0;
    forever begin
      mode = $urandom_range(0, 3);
      repeat ($urandom_range(10, 80)) begin
        @(negedge clk);
        cnt++;
        case (mode)
          0:       out_stall <= 1'b0;
          1:       out_stall <= ($urandom_range(0, 1) == 1);
          2:       out_stall <= ($urandom_range(0, 7) == 0);
          default: out_stall <= ((cnt % 13) < 9);
        endcase
      end
    end
  end

  // Sender: directed table, then random messages, in bursts
  initial begin
    int burst_left;
    int gap;
    int i;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data_byte = 8'h00;
    in_end_of_data = 1'b0;

    for (i = 0; i < N_DIRECTED; i++) stim_q.insert(stim_q.size(), DIRECTED_TBL[i]);
    while (stim_q.size() < N_DIRECTED + N_RANDOM_ITEMS) gen_message();

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    burst_left = 0;
    for (i = 0; i < stim_q.size(); i++) begin
      if (burst_left == 0) begin
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        if (gap > 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(negedge clk);
        end
        burst_left = ($urandom_range(0, 9) == 0) ? 200 : $urandom_range(1, 24);
      end
      // hold off until the output side has drained
      if ((i == N_DIRECTED || (i > 0 && i % 500 == 0)) && pending_results.size() != 0) begin
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge clk);
      end
      in_valid <= 1'b1;
      in_data_byte <= stim_q[i].data;
      in_end_of_data <= stim_q[i].eod;
      do @(posedge clk); while (in_stall);
      @(negedge clk);
      burst_left--;
    end
    in_valid <= 1'b0;

    while (pending_results.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);

    $display("Sent %0d bytes (%0d directed, %0d random messages); checked %0d payload,",
             accepted_bytes, N_DIRECTED, msg_count, n_payload);
    $display("%0d completion and %0d error results.", n_complete, n_error);
    if (err_cnt == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Watchdog
  initial begin
    #1000000;
    $display("Timeout with %0d results still expected", pending_results.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ----- http_chunked_body_decoder_unit.f -----
hdl/chbd_pkg.sv
hdl/chbd_front.sv
hdl/chbd_queue.sv
hdl/chbd_back.sv
hdl/http_chunked_body_decoder_unit.sv
tb/http_chunked_body_decoder_unit_tb.sv
